FILE: rtl/core/lnasm_pkg.sv
// Shared constants, types and helper functions of the line assembler.
package lnasm_pkg;

  localparam int LINE_MAX    = 64;
  localparam int QUEUE_DEPTH = 8;

  localparam int LB_AW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PEND_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QS_DEPTH = QUEUE_DEPTH * LINE_MAX;
  localparam int QS_AW    = (QS_DEPTH > 1) ? $clog2(QS_DEPTH) : 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_DROP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    RES_STORED   = 4'd0,
    RES_SKIPPED  = 4'd1,
    RES_QUEUED   = 4'd2,
    RES_BLANK    = 4'd3,
    RES_OVERFLOW = 4'd4,
    RES_DISABLED = 4'd5,
    RES_EMPTY    = 4'd6,
    RES_CHAR     = 4'd7,
    RES_CLEARED  = 4'd8
  } res_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_READ
  } state_e;

  // Command to the line tracker.
  typedef struct packed {
    logic       clear;
    logic       push;
    logic [7:0] data;
  } line_cmd_t;

  // Status of the partial line: length and the non-blank span [lo, hi).
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             seen;
    logic [LB_AW-1:0] lo;
    logic [LEN_W-1:0] hi;
  } line_sts_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [QS_AW-1:0] qs_addr(logic [SLOT_W-1:0] s,
                                               logic [LB_AW-1:0] i);
    return QS_AW'(int'(s) * LINE_MAX + int'(i));
  endfunction

endpackage

FILE: rtl/core/line_assembler_with_drop_oldest_queue_unit.sv
// Top level of the line assembler with a drop-oldest line queue.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  request  | start_i / busy_o          | req_type_i, data_byte_i, packet_start_i
//  result   | result_valid_o (strobe)   | result_code_o, line_char_o, last_o,
//           |                           | oldest_dropped_o, pending_lines_o,
//           |                           | lines_total_o, writes_total_o
//  config   | cfg_we_i                  | cfg_enable_i
//
// A byte, drop or clear beat has its result show in the next cycle. Reading a
// line holds busy while its characters stream; they come one per cycle from
// the queue RAM read port, each RAM read registered alongside its result beat.
// Queueing a trimmed line holds busy while it is copied, one character copied
// per cycle from the line RAM to the queue RAM.
// Reset clears all control state at once; the RAMs need no clearing pass.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module line_assembler_with_drop_oldest_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_enable_i,
  // result
  output logic        result_valid_o,
  output logic [3:0]  result_code_o,
  output logic [7:0]  line_char_o,
  output logic        last_o,
  output logic        oldest_dropped_o,
  output logic [3:0]  pending_lines_o,
  output logic [31:0] lines_total_o,
  output logic [31:0] writes_total_o
);

  localparam int LB_AW  = lnasm_pkg::LB_AW;
  localparam int LEN_W  = lnasm_pkg::LEN_W;
  localparam int SLOT_W = lnasm_pkg::SLOT_W;
  localparam int PEND_W = lnasm_pkg::PEND_W;
  localparam int QS_AW  = lnasm_pkg::QS_AW;

  lnasm_pkg::state_e state_q, state_d;

  logic              enable_q, enable_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [31:0]       lines_q, lines_d;
  logic [31:0]       writes_q, writes_d;

  // result beat register
  logic              ovalid_q, ovalid_d;
  lnasm_pkg::res_e   ocode_q, ocode_d;
  logic              olast_q, olast_d;
  logic              odrop_q, odrop_d;
  logic              ocsel_q, ocsel_d;

  // streaming and copy sequencer
  logic [SLOT_W-1:0] seq_slot_q, seq_slot_d;
  logic [LEN_W-1:0]  seq_len_q, seq_len_d;
  logic [LB_AW-1:0]  seq_idx_q, seq_idx_d;
  logic [LB_AW-1:0]  cp_lo_q, cp_lo_d;

  // delayed queue RAM write for the copy (line RAM read latency)
  logic              qwr_q, qwr_d;
  logic [QS_AW-1:0]  qwr_addr_q, qwr_addr_d;

  logic [LEN_W-1:0]  slot_len_q [lnasm_pkg::QUEUE_DEPTH];
  logic              slot_we;
  logic [LEN_W-1:0]  slot_wdata;

  lnasm_pkg::line_cmd_t line_cmd;
  lnasm_pkg::line_sts_t line_sts;

  logic              lb_we;
  logic [LB_AW-1:0]  lb_raddr;
  logic [7:0]        lb_rdata;
  logic [QS_AW-1:0]  qs_raddr;
  logic [7:0]        qs_rdata;

  logic              accept;
  logic [LEN_W-1:0]  trim_len;
  logic              seq_final;

  assign accept    = start_i && (state_q == lnasm_pkg::ST_IDLE);
  assign trim_len  = line_sts.hi - LEN_W'(line_sts.lo);
  assign seq_final = ((LEN_W'(seq_idx_q) + LEN_W'(1)) == seq_len_q);

  lnasm_line u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (line_cmd),
    .sts_o  (line_sts)
  );

  lnasm_ram #(
    .WIDTH (8),
    .DEPTH (lnasm_pkg::LINE_MAX)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (line_sts.len[LB_AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  lnasm_ram #(
    .WIDTH (8),
    .DEPTH (lnasm_pkg::QS_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qwr_q),
    .waddr_i (qwr_addr_q),
    .wdata_i (lb_rdata),
    .raddr_i (qs_raddr),
    .rdata_o (qs_rdata)
  );

  always_comb begin
    state_d    = state_q;
    enable_d   = enable_q;
    rd_slot_d  = rd_slot_q;
    wr_slot_d  = wr_slot_q;
    pend_d     = pend_q;
    lines_d    = lines_q;
    writes_d   = writes_q;
    ovalid_d   = 1'b0;
    ocode_d    = ocode_q;
    olast_d    = 1'b1;
    odrop_d    = 1'b0;
    ocsel_d    = 1'b0;
    seq_slot_d = seq_slot_q;
    seq_len_d  = seq_len_q;
    seq_idx_d  = seq_idx_q;
    cp_lo_d    = cp_lo_q;
    qwr_d      = 1'b0;
    qwr_addr_d = qwr_addr_q;
    slot_we    = 1'b0;
    slot_wdata = trim_len;
    line_cmd   = '0;
    line_cmd.data = data_byte_i;
    lb_we      = 1'b0;
    lb_raddr   = LB_AW'(cp_lo_q + seq_idx_q);
    qs_raddr   = lnasm_pkg::qs_addr(seq_slot_q, seq_idx_q);

    case (state_q)
      lnasm_pkg::ST_IDLE: begin
        if (accept) begin
          ovalid_d = 1'b1;
          case (lnasm_pkg::req_e'(req_type_i))
            lnasm_pkg::REQ_READ: begin
              if (pend_q == '0) begin
                ocode_d = lnasm_pkg::RES_EMPTY;
              end else begin
                // pop the oldest slot and stream it
                rd_slot_d  = lnasm_pkg::next_slot(rd_slot_q);
                pend_d     = pend_q - PEND_W'(1);
                seq_slot_d = rd_slot_q;
                seq_len_d  = slot_len_q[rd_slot_q];
                seq_idx_d  = '0;
                if (slot_len_q[rd_slot_q] == '0) begin
                  ocode_d = lnasm_pkg::RES_EMPTY;
                end else begin
                  ovalid_d = 1'b0;
                  state_d  = lnasm_pkg::ST_READ;
                end
              end
            end
            lnasm_pkg::REQ_DROP: begin
              line_cmd.clear = 1'b1;
              ocode_d        = lnasm_pkg::RES_CLEARED;
            end
            lnasm_pkg::REQ_CLEAR: begin
              rd_slot_d = '0;
              wr_slot_d = '0;
              pend_d    = '0;
              ocode_d   = lnasm_pkg::RES_CLEARED;
            end
            default: begin
              if (!enable_q) begin
                ocode_d = lnasm_pkg::RES_DISABLED;
              end else begin
                if (packet_start_i) begin
                  writes_d = writes_q + 32'd1;
                end
                if (data_byte_i == lnasm_pkg::CH_CR) begin
                  ocode_d = lnasm_pkg::RES_SKIPPED;
                end else if (data_byte_i == lnasm_pkg::CH_LF) begin
                  if (line_sts.len == '0) begin
                    ocode_d = lnasm_pkg::RES_SKIPPED;
                  end else if (!line_sts.seen) begin
                    line_cmd.clear = 1'b1;
                    ocode_d        = lnasm_pkg::RES_BLANK;
                  end else begin
                    // queue the trimmed line; drop the oldest when full
                    line_cmd.clear = 1'b1;
                    ocode_d        = lnasm_pkg::RES_QUEUED;
                    if (pend_q == PEND_W'(lnasm_pkg::QUEUE_DEPTH)) begin
                      rd_slot_d = lnasm_pkg::next_slot(rd_slot_q);
                      odrop_d   = 1'b1;
                    end else begin
                      pend_d = pend_q + PEND_W'(1);
                    end
                    slot_we    = 1'b1;
                    wr_slot_d  = lnasm_pkg::next_slot(wr_slot_q);
                    lines_d    = lines_q + 32'd1;
                    seq_slot_d = wr_slot_q;
                    seq_len_d  = trim_len;
                    seq_idx_d  = '0;
                    cp_lo_d    = line_sts.lo;
                    state_d    = lnasm_pkg::ST_COPY;
                  end
                end else if (line_sts.len >= LEN_W'(lnasm_pkg::LINE_MAX)) begin
                  line_cmd.clear = 1'b1;
                  ocode_d        = lnasm_pkg::RES_OVERFLOW;
                end else begin
                  lb_we         = 1'b1;
                  line_cmd.push = 1'b1;
                  ocode_d       = lnasm_pkg::RES_STORED;
                end
              end
            end
          endcase
        end
      end
      lnasm_pkg::ST_COPY: begin
        // read one character of the span, write it to the slot next cycle
        qwr_d      = 1'b1;
        qwr_addr_d = lnasm_pkg::qs_addr(seq_slot_q, seq_idx_q);
        seq_idx_d  = seq_idx_q + LB_AW'(1);
        if (seq_final) begin
          state_d = lnasm_pkg::ST_IDLE;
        end
      end
      lnasm_pkg::ST_READ: begin
        // issue one character read; the beat goes out with the RAM data
        ovalid_d  = 1'b1;
        ocode_d   = lnasm_pkg::RES_CHAR;
        ocsel_d   = 1'b1;
        olast_d   = seq_final;
        seq_idx_d = seq_idx_q + LB_AW'(1);
        if (seq_final) begin
          state_d = lnasm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lnasm_pkg::ST_IDLE;
      end
    endcase

    // enable changes drop the partial line; falling also empties the queue
    if (cfg_we_i && (cfg_enable_i != enable_q)) begin
      line_cmd.clear = 1'b1;
      if (!cfg_enable_i) begin
        rd_slot_d = '0;
        wr_slot_d = '0;
        pend_d    = '0;
      end
    end
    if (cfg_we_i) begin
      enable_d = cfg_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lnasm_pkg::ST_IDLE;
      enable_q  <= 1'b0;
      rd_slot_q <= '0;
      wr_slot_q <= '0;
      pend_q    <= '0;
      lines_q   <= '0;
      writes_q  <= '0;
      ovalid_q  <= 1'b0;
      qwr_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      enable_q  <= enable_d;
      rd_slot_q <= rd_slot_d;
      wr_slot_q <= wr_slot_d;
      pend_q    <= pend_d;
      lines_q   <= lines_d;
      writes_q  <= writes_d;
      ovalid_q  <= ovalid_d;
      qwr_q     <= qwr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ocode_q    <= ocode_d;
    olast_q    <= olast_d;
    odrop_q    <= odrop_d;
    ocsel_q    <= ocsel_d;
    seq_slot_q <= seq_slot_d;
    seq_len_q  <= seq_len_d;
    seq_idx_q  <= seq_idx_d;
    cp_lo_q    <= cp_lo_d;
    qwr_addr_q <= qwr_addr_d;
    if (slot_we) begin
      slot_len_q[wr_slot_q] <= slot_wdata;
    end
  end

  assign busy_o           = (state_q != lnasm_pkg::ST_IDLE);
  assign result_valid_o   = ovalid_q;
  assign result_code_o    = ocode_q;
  assign line_char_o      = ocsel_q ? qs_rdata : 8'h00;
  assign last_o           = olast_q;
  assign oldest_dropped_o = odrop_q;
  assign pending_lines_o  = 4'(pend_q);
  assign lines_total_o    = lines_q;
  assign writes_total_o   = writes_q;

endmodule

FILE: rtl/core/lnasm_ram.sv
// Generic simple dual-port RAM with registered read.
module lnasm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lnasm_line.sv
// Partial line tracker: length and non-blank span of the line being built.
module lnasm_line (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lnasm_pkg::line_cmd_t  cmd_i,
  output lnasm_pkg::line_sts_t  sts_o
);

  logic [lnasm_pkg::LEN_W-1:0] len_q, len_d;
  logic                        seen_q, seen_d;
  logic [lnasm_pkg::LB_AW-1:0] lo_q, lo_d;
  logic [lnasm_pkg::LEN_W-1:0] hi_q, hi_d;

  always_comb begin
    len_d  = len_q;
    seen_d = seen_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (cmd_i.clear) begin
      len_d  = '0;
      seen_d = 1'b0;
    end else if (cmd_i.push) begin
      len_d = len_q + lnasm_pkg::LEN_W'(1);
      // track first and last non-blank character for trimming
      if (!lnasm_pkg::is_space(cmd_i.data)) begin
        if (!seen_q) begin
          lo_d = len_q[lnasm_pkg::LB_AW-1:0];
        end
        hi_d   = len_q + lnasm_pkg::LEN_W'(1);
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign sts_o.len  = len_q;
  assign sts_o.seen = seen_q;
  assign sts_o.lo   = lo_q;
  assign sts_o.hi   = hi_q;

endmodule

FILE: rtl/core/lnasm_chk.sv
// Port-level checker for the line assembler, bound to the top level.
module lnasm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  req_type_i,
  input logic        result_valid_o,
  input logic [3:0]  result_code_o,
  input logic [7:0]  line_char_o,
  input logic        last_o,
  input logic [3:0]  pending_lines_o
);

  // any request other than a read answers with one final beat next cycle
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i != lnasm_pkg::REQ_READ))
      |=> (result_valid_o && last_o))
    else $error("single-beat request did not answer next cycle");

  a_nonchar_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_code_o != lnasm_pkg::RES_CHAR)) |-> last_o)
    else $error("status beat without last mark");

  a_nonchar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_code_o != lnasm_pkg::RES_CHAR)) |-> (line_char_o == 8'h00))
    else $error("status beat carries a character");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_lines_o <= 4'(lnasm_pkg::QUEUE_DEPTH))
    else $error("pending line count beyond queue depth");

  // a character beat that is not last is followed by another character beat
  a_stream_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_code_o == lnasm_pkg::RES_CHAR) && !last_o)
      |=> (result_valid_o && (result_code_o == lnasm_pkg::RES_CHAR)))
    else $error("line stream broken before last beat");

endmodule

bind line_assembler_with_drop_oldest_queue_unit lnasm_chk u_lnasm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .req_type_i      (req_type_i),
  .result_valid_o  (result_valid_o),
  .result_code_o   (result_code_o),
  .line_char_o     (line_char_o),
  .last_o          (last_o),
  .pending_lines_o (pending_lines_o)
);
